/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, payload types and controller/datapath signal groups for
// the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int ROWS      = 25;
	localparam int COLS      = 80;
	localparam int CELLS     = ROWS * COLS;
	localparam int LAST_ROW  = CELLS - COLS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int COL_W     = $clog2(COLS);
	localparam int ROW_W     = $clog2(ROWS);
	localparam int LIN_SHIFT = 17;
	localparam int LIN_RECIP = (1 << LIN_SHIFT) / COLS + 1;

	localparam logic [7:0] TEXT_ATTR = 8'h07;
	localparam logic [7:0] LINE_FEED = 8'h0A;
	localparam logic [7:0] SPACE     = 8'h20;

	typedef enum logic [2:0] {
		OP_PUT_RAW  = 3'd0,
		OP_PUT_TEXT = 3'd1,
		OP_PUT_AT   = 3'd2,
		OP_MOVE_RC  = 3'd3,
		OP_MOVE_LIN = 3'd4,
		OP_READ     = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  char_code;
		logic [7:0]  attr;
		logic [4:0]  row;
		logic [6:0]  col;
		logic [10:0] position;
	} req_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
		logic        ignored;
	} rsp_t;

	typedef struct packed {
		logic load_req;
		logic exec;
		logic rd_capture;
		logic mod_step;
		logic copy_step;
		logic flush;
		logic blank_step;
		logic clear_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic scroll;
		logic read;
		logic modulo;
		logic copy_last;
		logic fill_last;
		logic out_free;
	} dp_sts_t;

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_EXEC   = 9'b000000100,
		ST_RDWAIT = 9'b000001000,
		ST_MODDIV = 9'b000010000,
		ST_COPY   = 9'b000100000,
		ST_FLUSH  = 9'b001000000,
		ST_BLANK  = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

endpackage

`default_nettype wire

/* src/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: clearing pass, request execution, read wait, column recovery,
// scroll copy and bottom-row blanking, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	input  tcw_pkg::dp_sts_t  sts,
	output tcw_pkg::dp_cmd_t  cmd
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.fill_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.scroll)      state_d = ST_COPY;
				else if (sts.read)   state_d = ST_RDWAIT;
				else if (sts.modulo) state_d = ST_MODDIV;
				else                 state_d = ST_DONE;
			end
			ST_RDWAIT: begin
				cmd.rd_capture = 1'b1;
				state_d        = ST_DONE;
			end
			ST_MODDIV: begin
				cmd.mod_step = 1'b1;
				state_d      = ST_DONE;
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_last) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = ST_BLANK;
			end
			ST_BLANK: begin
				cmd.blank_step = 1'b1;
				if (sts.fill_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != ST_IDLE);

endmodule

`default_nettype wire

/* src/tcw_dp.sv */
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: cell memory, cursor and column registers, sweep counter,
// remainder register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_dp (
	input  wire               clk,
	input  wire               arst_n,
	input  tcw_pkg::req_t     req,
	output tcw_pkg::rsp_t     rsp,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	input  tcw_pkg::dp_cmd_t  cmd,
	output tcw_pkg::dp_sts_t  sts
);
	import tcw_pkg::*;

	logic [15:0]       mem [CELLS];
	logic [15:0]       rd_data_q;

	req_t              req_q;
	logic [ADDR_W-1:0] cursor_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] rem_q;
	logic [ROW_W-1:0]  lin_row_q;
	logic              pend_q;
	logic [ADDR_W-1:0] pend_addr_q;
	logic [7:0]        res_char_q;
	logic [7:0]        res_attr_q;
	logic              res_ign_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	op_t               op;
	logic              rc_ok;
	logic              pos_ok;
	logic [ADDR_W-1:0] lin;
	logic              cur_last;
	logic [ADDR_W-1:0] row_start;
	logic              on_last;
	logic              is_lf;
	logic              is_put;
	logic              ign_c;
	logic [7:0]        put_attr;
	logic [2*ADDR_W-1:0] recip_prod;
	logic [ROW_W-1:0]  lin_row;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [15:0]       wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;

	always_comb begin
		op         = op_t'(req_q.opcode);
		rc_ok      = (int'(req_q.row) < ROWS) && (int'(req_q.col) < COLS);
		pos_ok     = int'(req_q.position) < CELLS;
		lin        = ADDR_W'(int'(req_q.row) * COLS + int'(req_q.col));
		cur_last   = cursor_q == ADDR_W'(CELLS - 1);
		row_start  = cursor_q - ADDR_W'(col_q);
		on_last    = row_start == ADDR_W'(LAST_ROW);
		is_lf      = (op == OP_PUT_TEXT) && (req_q.char_code == LINE_FEED);
		is_put     = (op == OP_PUT_RAW) || ((op == OP_PUT_TEXT) && !is_lf);
		put_attr   = (op == OP_PUT_TEXT) ? TEXT_ATTR : req_q.attr;
		recip_prod = {{ADDR_W{1'b0}}, req_q.position} * (2*ADDR_W)'(LIN_RECIP);
		lin_row    = ROW_W'(recip_prod >> LIN_SHIFT);
		case (op)
			OP_PUT_RAW, OP_PUT_TEXT:        ign_c = 1'b0;
			OP_PUT_AT, OP_MOVE_RC, OP_READ: ign_c = !rc_ok;
			OP_MOVE_LIN:                    ign_c = !pos_ok;
			default:                        ign_c = 1'b1;
		endcase
	end

	always_comb begin
		sts.scroll    = (is_put && cur_last) || (is_lf && on_last);
		sts.read      = (op == OP_READ) && rc_ok;
		sts.modulo    = (op == OP_MOVE_LIN) && pos_ok;
		sts.copy_last = cnt_q == ADDR_W'(LAST_ROW - 1);
		sts.fill_last = cnt_q == ADDR_W'(CELLS - 1);
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = '0;
		if (pend_q) begin
			we    = 1'b1;
			waddr = pend_addr_q;
			wdata = rd_data_q;
		end else if (cmd.clear_step) begin
			we    = 1'b1;
		end else if (cmd.blank_step) begin
			we    = 1'b1;
			wdata = {TEXT_ATTR, SPACE};
		end else if (cmd.exec && is_put) begin
			we    = 1'b1;
			waddr = cursor_q;
			wdata = {put_attr, req_q.char_code};
		end else if (cmd.exec && (op == OP_PUT_AT) && rc_ok) begin
			we    = 1'b1;
			waddr = lin;
			wdata = {req_q.attr, req_q.char_code};
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = lin;
		if (cmd.copy_step) begin
			re    = 1'b1;
			raddr = cnt_q + ADDR_W'(COLS);
		end else if (cmd.exec && sts.read) begin
			re    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_q <= cmd.copy_step;
			if (cmd.clear_step || cmd.blank_step || cmd.copy_step) begin
				cnt_q <= sts.fill_last ? '0 : cnt_q + 1'b1;
			end else if (cmd.flush) begin
				cnt_q <= ADDR_W'(LAST_ROW);
			end
			if (cmd.exec) begin
				if (is_put) begin
					if (cur_last) begin
						cursor_q <= ADDR_W'(LAST_ROW);
						col_q    <= '0;
					end else begin
						cursor_q <= cursor_q + 1'b1;
						col_q    <= (int'(col_q) == COLS - 1) ? '0 : col_q + 1'b1;
					end
				end else if (is_lf) begin
					cursor_q <= on_last ? ADDR_W'(LAST_ROW) : row_start + ADDR_W'(COLS);
					col_q    <= '0;
				end else if ((op == OP_MOVE_RC) && rc_ok) begin
					cursor_q <= lin;
					col_q    <= COL_W'(req_q.col);
				end else if ((op == OP_MOVE_LIN) && pos_ok) begin
					cursor_q <= ADDR_W'(req_q.position);
				end
			end
			if (cmd.mod_step) begin
				col_q <= COL_W'(rem_q - ADDR_W'(lin_row_q) * ADDR_W'(COLS));
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
		if (cmd.copy_step) pend_addr_q <= cnt_q;
		if (cmd.exec) begin
			res_char_q <= '0;
			res_attr_q <= '0;
			res_ign_q  <= ign_c;
			rem_q      <= ADDR_W'(req_q.position);
			lin_row_q  <= lin_row;
		end
		if (cmd.rd_capture) begin
			res_char_q <= rd_data_q[7:0];
			res_attr_q <= rd_data_q[15:8];
		end
		if (cmd.load_out) begin
			rsp_q.cursor_pos <= 11'(cursor_q);
			rsp_q.cell_char  <= res_char_q;
			rsp_q.cell_attr  <= res_attr_q;
			rsp_q.ignored    <= res_ign_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

/* src/text_console_writer_top.sv */
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console: ROWS x COLS cells of character and attribute,
// a linear cursor, scrolling and a one-cell read port.
// ----------------------------------------------------------------------------
// One request at a time, one response per request. After reset the cell
// memory is swept to zero, one cell a cycle, so no request is taken until
// the sweep is done. A put, a line feed or a row/column move occupies the
// block for an accept, an execute on the memory write port and a response
// load; a read adds a wait for the registered memory read, and a linear move
// adds a column recovery by reciprocal multiplication. The response is
// registered in the response load, which waits for the output register to
// be free. A scroll walks the memory through its one read and one write
// port: a copy pass, a flush and a blanking pass over the bottom row, between
// the execute and the response load. A waiting response does not hold up
// the next acceptance, but the next response waits for it to be taken.
`default_nettype none

module text_console_writer_top (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  tcw_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output tcw_pkg::rsp_t  rsp
);
	import tcw_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire
